### design/lac_pkg.sv
// lac_pkg: shared codes and the class-to-lane route table for the lane admission controller
// no dependencies

package lac_pkg;

    // operation codes
    localparam logic [1:0] FN_ADMIT   = 2'd0;
    localparam logic [1:0] FN_CHECK   = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;
    localparam logic [1:0] FN_CANCEL  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ADMITTED  = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_WRONG_LN  = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_UNDERFLOW = 3'd6;

    // envelope kinds and dispositions
    localparam logic       KIND_COMMAND  = 1'b0;
    localparam logic       KIND_RESULT   = 1'b1;
    localparam logic [1:0] DISP_ACCEPTED = 2'd0;

    // configuration register indexes
    localparam logic CFG_LANE_CAPS   = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4096;

    // route targets, five bits so that no route never matches a lane
    localparam logic [4:0] RESULT_LANE = 5'd2;
    localparam logic [4:0] NO_ROUTE    = 5'd16;

    function automatic logic [4:0] class_route(input logic [3:0] cls);
        logic [4:0] rt;
        case (cls)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: rt = {1'b0, cls};
            4'd6, 4'd7:                        rt = 5'd6;
            4'd8:                              rt = 5'd7;
            default:                           rt = NO_ROUTE;
        endcase
        return rt;
    endfunction

endpackage

### design/lane_admission_controller_top.sv
// lane_admission_controller_top: admission control over task lanes and work classes
// depends on lac_pkg
// Each accepted word is one request (admit, check, release or cancel) and yields exactly one
// result word. In the accept cycle the lane occupancy memory and the class floor memory are
// read at the item's lane and class into registers; the checks then run on the read data,
// and when the item completes the updated entry is written back while the result is loaded
// into the output register. The input stalls while an item is in flight, so a new item is
// taken only after the last one has completed. The output register lets the next item be
// taken while a result waits; a stalled output holds the item in flight until the result
// register frees up. Both memories clear at reset through per-entry valid bits, so no
// clearing pass is needed. Configuration (lane capacities, largest payload) is written
// through its own valid/ready port, which is always ready, and must only change while the
// block is idle.

module lane_admission_controller_top #(
    parameter int LANE_COUNT  = 8,
    parameter int CLASS_COUNT = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,

    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_lane,
    input  logic [3:0]  i_job_class,
    input  logic        i_envelope_kind,
    input  logic [1:0]  i_disposition,
    input  logic [63:0] i_generation,
    input  logic [31:0] i_req_tag,
    input  logic [31:0] i_pay_size,
    input  logic [31:0] i_due_time,
    input  logic [31:0] i_now_ms,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_lane_used,
    output logic [63:0] o_class_floor
);

    import lac_pkg::*;

    // address widths of the two memories
    localparam int LW = (LANE_COUNT  > 1) ? $clog2(LANE_COUNT)  : 1;
    localparam int CW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    // limits for the range checks on the four-bit lane and class fields
    localparam logic [4:0] LANE_LIM  = 5'(LANE_COUNT);
    localparam logic [4:0] CLASS_LIM = 5'(CLASS_COUNT);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] r_lane_caps;
    logic [31:0] r_max_payload;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_caps   <= '0;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LANE_CAPS:   r_lane_caps   <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake and item register
    // ------------------------------------------------------------------
    logic r_busy;        // an item is in flight, from accept until it completes
    logic r_out_valid;
    logic in_acc;
    logic complete;      // item finishes: result loaded, write-back done

    assign o_in_stall = r_busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign complete   = r_busy && (!r_out_valid || !i_out_stall);

    logic [1:0]  r_func;
    logic [3:0]  r_lane;
    logic [3:0]  r_class;
    logic        r_kind;
    logic [1:0]  r_disp;
    logic [63:0] r_gen;
    logic [31:0] r_rid;
    logic [31:0] r_pay;
    logic [31:0] r_deadline;
    logic [31:0] r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else if (complete) begin
            r_busy <= 1'b0;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func     <= i_func;
            r_lane     <= i_lane;
            r_class    <= i_job_class;
            r_kind     <= i_envelope_kind;
            r_disp     <= i_disposition;
            r_gen      <= i_generation;
            r_rid      <= i_req_tag;
            r_pay      <= i_pay_size;
            r_deadline <= i_due_time;
            r_now      <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // state memories: lane occupancy and class generation floor
    // entries without their valid bit read as zero
    // ------------------------------------------------------------------
    logic [7:0]             occ_mem [LANE_COUNT];
    logic [63:0]            flr_mem [CLASS_COUNT];
    logic [LANE_COUNT-1:0]  r_occ_vld;
    logic [CLASS_COUNT-1:0] r_flr_vld;

    logic [7:0]  r_occ_rd;
    logic        r_occ_rd_vld;
    logic [63:0] r_flr_rd;
    logic        r_flr_rd_vld;

    logic        in_lane_ok;
    logic        in_class_ok;

    assign in_lane_ok  = {1'b0, i_lane}      < LANE_LIM;
    assign in_class_ok = {1'b0, i_job_class} < CLASS_LIM;

    // read port: issued in the accept cycle, data registered
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (in_lane_ok) begin
                r_occ_rd <= occ_mem[i_lane[LW-1:0]];
            end
            if (in_class_ok) begin
                r_flr_rd <= flr_mem[i_job_class[CW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_rd_vld <= 1'b0;
            r_flr_rd_vld <= 1'b0;
        end else if (in_acc) begin
            r_occ_rd_vld <= in_lane_ok  && r_occ_vld[i_lane[LW-1:0]];
            r_flr_rd_vld <= in_class_ok && r_flr_vld[i_job_class[CW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // checks and update, on the registered read data, held until the item completes
    // ------------------------------------------------------------------
    logic        lane_ok;
    logic        class_ok;
    logic [7:0]  occ_cur;
    logic [63:0] flr_cur;
    logic [7:0]  lane_cap;
    logic [4:0]  route;
    logic [31:0] dl_diff;
    logic        bad_envelope;
    logic [2:0]  chk_status;

    logic [2:0]  n_status;
    logic [7:0]  n_occ;
    logic [63:0] n_flr;
    logic        occ_we;
    logic        flr_we;

    assign lane_ok  = {1'b0, r_lane}  < LANE_LIM;
    assign class_ok = {1'b0, r_class} < CLASS_LIM;
    assign occ_cur  = r_occ_rd_vld ? r_occ_rd : 8'd0;
    assign flr_cur  = r_flr_rd_vld ? r_flr_rd : 64'd0;

    // lanes beyond the eight packed capacities have none
    assign lane_cap = r_lane[3] ? 8'd0 : r_lane_caps[{r_lane[2:0], 3'b000} +: 8];

    assign route   = (r_kind == KIND_RESULT) ? RESULT_LANE : class_route(r_class);
    assign dl_diff = r_now - r_deadline;

    assign bad_envelope = !lane_ok || !class_ok || (r_gen == 64'd0) || (r_rid == 32'd0)
                       || (r_pay > r_max_payload)
                       || ((r_kind == KIND_COMMAND) && (r_disp != DISP_ACCEPTED))
                       || ((r_kind == KIND_RESULT)  && (r_disp == DISP_ACCEPTED));

    // validation in priority order; deadline is a signed compare across wrap
    always_comb begin
        if (bad_envelope) begin
            chk_status = ST_INVALID;
        end else if (route != {1'b0, r_lane}) begin
            chk_status = ST_WRONG_LN;
        end else if (r_gen < flr_cur) begin
            chk_status = ST_STALE;
        end else if ((r_deadline != 32'd0) && !dl_diff[31]) begin
            chk_status = ST_EXPIRED;
        end else begin
            chk_status = ST_ADMITTED;
        end
    end

    always_comb begin
        n_status = ST_ADMITTED;
        n_occ    = occ_cur;
        n_flr    = flr_cur;
        occ_we   = 1'b0;
        flr_we   = 1'b0;
        unique case (r_func)
            FN_ADMIT: begin
                n_status = chk_status;
                if (chk_status == ST_ADMITTED) begin
                    // a zero capacity makes the lane permanently full
                    if ((lane_cap == 8'd0) || (occ_cur >= lane_cap)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_occ  = occ_cur + 8'd1;
                        occ_we = 1'b1;
                    end
                end
            end
            FN_CHECK: begin
                n_status = chk_status;
            end
            FN_RELEASE: begin
                if (!lane_ok) begin
                    n_status = ST_WRONG_LN;
                end else if (occ_cur == 8'd0) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_occ  = occ_cur - 8'd1;
                    occ_we = 1'b1;
                end
            end
            FN_CANCEL: begin
                // the floor only ever rises
                if (!class_ok || (r_gen == 64'd0)) begin
                    n_status = ST_INVALID;
                end else if (r_gen > flr_cur) begin
                    n_flr  = r_gen;
                    flr_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // write port: one write per memory at completion
    always_ff @(posedge i_clk) begin
        if (complete && occ_we) begin
            occ_mem[r_lane[LW-1:0]] <= n_occ;
        end
        if (complete && flr_we) begin
            flr_mem[r_class[CW-1:0]] <= n_flr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_vld <= '0;
            r_flr_vld <= '0;
        end else if (complete) begin
            if (occ_we) begin
                r_occ_vld[r_lane[LW-1:0]] <= 1'b1;
            end
            if (flr_we) begin
                r_flr_vld[r_class[CW-1:0]] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [2:0]  r_status;
    logic [7:0]  r_lane_used;
    logic [63:0] r_class_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (complete) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_status      <= n_status;
            r_lane_used   <= lane_ok  ? n_occ : 8'd0;
            r_class_floor <= class_ok ? n_flr : 64'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_lane_used   = r_lane_used;
    assign o_class_floor = r_class_floor;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted word holds off the next one while its read is in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("accepted word did not stall the input");

    // every completed item shows up on the output
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        complete |=> o_out_valid)
        else $error("completed item produced no result");

    // admission never pushes a lane past its capacity
    a_occ_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (complete && occ_we && (r_func == FN_ADMIT)) |-> (n_occ <= lane_cap && n_occ != 8'd0))
        else $error("lane occupancy exceeded capacity");

    // release never wraps an empty lane
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (complete && occ_we && (r_func == FN_RELEASE)) |-> (occ_cur != 8'd0))
        else $error("lane occupancy underflow");

    // class floors are monotonic
    a_floor_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (complete && flr_we) |-> (n_flr > flr_cur))
        else $error("class floor decreased");

endmodule

### bench/lac_score_pkg.sv
`timescale 1ns / 100ps
// lac_score_pkg: request and result word types plus the admission scoreboard for the bench
// depends on lac_pkg for operation, status and register codes

package lac_score_pkg;
    import lac_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  lane;
        logic [3:0]  job_class;
        logic        kind;
        logic [1:0]  disp;
        logic [63:0] generation;
        logic [31:0] req_tag;
        logic [31:0] pay_size;
        logic [31:0] due_time;
        logic [31:0] now_ms;
    } t_lac_req;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  lane_used;
        logic [63:0] class_floor;
    } t_lac_outcome;

    class admission_scoreboard;
        logic [63:0]  lane_caps;
        logic [31:0]  payload_limit;
        logic [7:0]   occupancy [8];
        logic [63:0]  floors [9];
        t_lac_outcome outcome_q [$];
        int unsigned  mismatches;

        function new();
            lane_caps     = '0;
            payload_limit = MAX_PAYLOAD_RESET;
            foreach (occupancy[i]) occupancy[i] = '0;
            foreach (floors[i]) floors[i] = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic idx, logic [63:0] data);
            if (idx == CFG_LANE_CAPS) begin
                lane_caps = data;
            end else begin
                payload_limit = data[31:0];
            end
        endfunction

        // fixed route: results go to the control lane, commands by class
        function logic [4:0] lane_for(logic kind, logic [3:0] cls);
            if (kind == KIND_RESULT) return 5'd2;
            if (cls < 4'd6) return {1'b0, cls};
            if (cls < 4'd8) return 5'd6;
            if (cls == 4'd8) return 5'd7;
            return 5'd16;
        endfunction

        function logic [2:0] screen(t_lac_req r);
            logic [31:0] lag;
            if (r.lane > 4'd7 || r.job_class > 4'd8 || r.generation == '0 ||
                r.req_tag == '0 || r.pay_size > payload_limit ||
                (r.kind == KIND_COMMAND && r.disp != DISP_ACCEPTED) ||
                (r.kind == KIND_RESULT && r.disp == DISP_ACCEPTED)) return ST_INVALID;
            if (lane_for(r.kind, r.job_class) != {1'b0, r.lane}) return ST_WRONG_LN;
            if (r.generation < floors[r.job_class]) return ST_STALE;
            lag = r.now_ms - r.due_time;
            if (r.due_time != '0 && !lag[31]) return ST_EXPIRED;
            return ST_ADMITTED;
        endfunction

        function void note_request(t_lac_req r);
            t_lac_outcome o;
            logic [2:0]   st;
            logic [7:0]   cap;
            logic         lane_ok;
            logic         class_ok;
            int           ln;
            int           cl;
            ln       = r.lane;
            cl       = r.job_class;
            lane_ok  = (ln < 8);
            class_ok = (cl < 9);
            st       = ST_ADMITTED;
            case (r.func)
                FN_ADMIT, FN_CHECK: begin
                    st = screen(r);
                    if (r.func == FN_ADMIT && st == ST_ADMITTED) begin
                        cap = lane_caps[8*ln +: 8];
                        if (cap == '0 || occupancy[ln] >= cap) st = ST_FULL;
                        else occupancy[ln] = occupancy[ln] + 8'd1;
                    end
                end
                FN_RELEASE: begin
                    if (!lane_ok) st = ST_WRONG_LN;
                    else if (occupancy[ln] == '0) st = ST_UNDERFLOW;
                    else occupancy[ln] = occupancy[ln] - 8'd1;
                end
                FN_CANCEL: begin
                    if (!class_ok || r.generation == '0) st = ST_INVALID;
                    else if (r.generation > floors[cl]) floors[cl] = r.generation;
                end
            endcase
            o.status      = st;
            o.lane_used   = lane_ok ? occupancy[ln] : 8'd0;
            o.class_floor = class_ok ? floors[cl] : 64'd0;
            outcome_q.push_back(o);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [2:0] status, logic [7:0] used,
                                   logic [63:0] got_floor);
            t_lac_outcome want;
            if (outcome_q.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing outstanding, status %0d used %0d floor %0h",
                         $time, status, used, got_floor);
                return;
            end
            want = outcome_q.pop_front();
            compare_field("status", 64'(want.status), 64'(status));
            compare_field("lane_used", 64'(want.lane_used), 64'(used));
            compare_field("class_floor", want.class_floor, got_floor);
        endfunction
    endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for lane_admission_controller_top, directed words then random phases
// depends on lac_pkg, lac_score_pkg and the design sources

module tb_top;
    import lac_pkg::*;
    import lac_score_pkg::*;

    localparam int SINK_HOLD = 300;   // cycles of the long output hold-off
    localparam int PHASE_LEN = 100;   // random words per configuration phase
    localparam int PHASES    = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [3:0]  i_lane;
    logic [3:0]  i_job_class;
    logic        i_envelope_kind;
    logic [1:0]  i_disposition;
    logic [63:0] i_generation;
    logic [31:0] i_req_tag;
    logic [31:0] i_pay_size;
    logic [31:0] i_due_time;
    logic [31:0] i_now_ms;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_lane_used;
    logic [63:0] o_class_floor;

    lane_admission_controller_top DUT (.*);

    admission_scoreboard sb;
    bit                  hold_off_req;   // asks the result sink for one long hold-off
    int                  burst_left;     // words left in the current sender burst

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard limit, many times the slowest sensible run
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // both handshakes are observed in one place so that an input word is always
    // noted before any result word it could produce is checked
    always @(posedge i_clk) begin : observe
        t_lac_req seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                seen.func       = i_func;
                seen.lane       = i_lane;
                seen.job_class  = i_job_class;
                seen.kind       = i_envelope_kind;
                seen.disp       = i_disposition;
                seen.generation = i_generation;
                seen.req_tag    = i_req_tag;
                seen.pay_size   = i_pay_size;
                seen.due_time   = i_due_time;
                seen.now_ms     = i_now_ms;
                sb.note_request(seen);
            end
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_status, o_lane_used, o_class_floor);
        end
    end

    // result sink: segments of free flow, light, medium and heavy back-pressure,
    // plus a long hold-off on request so that the block fills and stalls its input
    initial begin : result_sink
        int unsigned mode;
        int unsigned span;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (SINK_HOLD) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span) begin
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                        2:       i_out_stall <= ($urandom_range(0, 1) == 0);
                        default: i_out_stall <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_lac_req make_word(logic [1:0] func, logic [3:0] lane,
                                           logic [3:0] cls, logic kind, logic [1:0] disp,
                                           logic [63:0] gen, logic [31:0] rid,
                                           logic [31:0] pay, logic [31:0] dl,
                                           logic [31:0] now);
        t_lac_req r;
        r.func       = func;
        r.lane       = lane;
        r.job_class  = cls;
        r.kind       = kind;
        r.disp       = disp;
        r.generation = gen;
        r.req_tag    = rid;
        r.pay_size   = pay;
        r.due_time   = dl;
        r.now_ms     = now;
        return r;
    endfunction

    // mostly well-formed words aimed at the current floors and payload limit,
    // with a share of pure noise and single broken fields
    function automatic t_lac_req next_word();
        t_lac_req    r;
        int unsigned pick;
        int unsigned cls;
        logic [63:0] base;
        logic [31:0] lim;
        pick         = $urandom_range(0, 99);
        lim          = sb.payload_limit;
        r.func       = 2'($urandom);
        r.lane       = 4'($urandom);
        r.job_class  = 4'($urandom);
        r.kind       = 1'($urandom);
        r.disp       = 2'($urandom);
        r.generation = {$urandom, $urandom};
        r.req_tag    = $urandom;
        r.pay_size   = $urandom;
        r.due_time   = $urandom;
        r.now_ms     = $urandom;
        if (pick < 12) return r;

        cls         = $urandom_range(0, 8);
        base        = sb.floors[cls];
        r.job_class = 4'(cls);
        r.kind      = ($urandom_range(0, 4) == 0) ? KIND_RESULT : KIND_COMMAND;
        r.disp      = (r.kind == KIND_RESULT) ? 2'($urandom_range(1, 3)) : DISP_ACCEPTED;
        // lane picked to match the route, so most admits get past the lane check
        if (r.kind == KIND_RESULT) r.lane = 4'd2;
        else if (cls < 6) r.lane = 4'(cls);
        else r.lane = (cls == 8) ? 4'd7 : 4'd6;

        case ($urandom_range(0, 5))
            0:       r.generation = {$urandom, $urandom} | 64'd1;
            1:       r.generation = base;
            2:       r.generation = base - 64'd1;
            default: r.generation = base + $urandom_range(1, 50);
        endcase
        r.req_tag = ($urandom_range(0, 29) == 0) ? 32'd0 : ($urandom | 32'd1);
        case ($urandom_range(0, 7))
            0:       r.pay_size = lim;
            1:       r.pay_size = lim + 32'd1;
            2:       r.pay_size = 32'd0;
            default: r.pay_size = (lim > 32'd65535) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, lim);
        endcase
        case ($urandom_range(0, 7))
            0, 1:    r.due_time = 32'd0;
            2:       r.due_time = r.now_ms;
            3:       r.due_time = r.now_ms - $urandom_range(1, 10000);
            4:       r.due_time = $urandom;
            default: r.due_time = r.now_ms + $urandom_range(1, 10000);
        endcase

        if (pick < 50) begin
            r.func = FN_ADMIT;
        end else if (pick < 60) begin
            r.func = FN_CHECK;
        end else if (pick < 85) begin
            r.func = FN_RELEASE;
            r.lane = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, 7));
        end else begin
            r.func = FN_CANCEL;
            if ($urandom_range(0, 9) == 0) r.job_class = 4'($urandom_range(9, 15));
            case ($urandom_range(0, 9))
                0:       r.generation = {$urandom, $urandom};
                1:       r.generation = 64'd0;
                2, 3, 4: r.generation = $urandom_range(0, 200);
                default: r.generation = base + $urandom_range(0, 20);
            endcase
        end
        // now and then one field knocked out of line
        if ($urandom_range(0, 9) == 0) r.lane = 4'($urandom);
        return r;
    endfunction

    // offers one word and holds it until taken; bursts of random length with
    // random gaps, valid only dropped when a real gap follows
    task automatic push_word(input t_lac_req r);
        int gap;
        i_func          <= r.func;
        i_lane          <= r.lane;
        i_job_class     <= r.job_class;
        i_envelope_kind <= r.kind;
        i_disposition   <= r.disp;
        i_generation    <= r.generation;
        i_req_tag       <= r.req_tag;
        i_pay_size      <= r.pay_size;
        i_due_time      <= r.due_time;
        i_now_ms        <= r.now_ms;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // every word yields one result, so once the queue is empty the block is idle;
    // spare cycles at the end cover the item and result registers
    task automatic settle();
        int waited;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (sb.outcome_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // writes both registers back to back, valid held high across the pair
    task automatic configure(input logic [63:0] caps, input logic [31:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LANE_CAPS;
        i_cfg_data  <= caps;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.set_reg(CFG_LANE_CAPS, caps);
        i_cfg_index <= CFG_MAX_PAYLOAD;
        i_cfg_data  <= {32'd0, limit};
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.set_reg(CFG_MAX_PAYLOAD, {32'd0, limit});
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [63:0] caps;
        logic [31:0] limit;
        int          phase;
        int          k;
        sb              = new();
        hold_off_req    = 1'b0;
        burst_left      = 0;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_LANE_CAPS;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_func          <= FN_ADMIT;
        i_lane          <= '0;
        i_job_class     <= '0;
        i_envelope_kind <= KIND_COMMAND;
        i_disposition   <= DISP_ACCEPTED;
        i_generation    <= '0;
        i_req_tag       <= '0;
        i_pay_size      <= '0;
        i_due_time      <= '0;
        i_now_ms        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every capacity zero, payload limit at its default
        push_word(make_word(FN_ADMIT, 0, 0, KIND_COMMAND, DISP_ACCEPTED, 1, 1, 4096, 0, 0));
        push_word(make_word(FN_CHECK, 0, 0, KIND_COMMAND, DISP_ACCEPTED, 1, 1, 4096, 0, 0));
        push_word(make_word(FN_CHECK, 0, 0, KIND_COMMAND, DISP_ACCEPTED, 1, 1, 4097, 0, 0));
        settle();

        // lane 7 holds two, lane 6 none, the rest one; no payload limit
        configure(64'h0200_0101_0101_0101, 32'hFFFF_FFFF);
        // field extremes through admit, then full, release, empty release
        push_word(make_word(FN_ADMIT, 0, 0, KIND_COMMAND, DISP_ACCEPTED, '1, '1, '1, 0, '1));
        push_word(make_word(FN_ADMIT, 0, 0, KIND_COMMAND, DISP_ACCEPTED, 5, 9, 0, 0, 0));
        push_word(make_word(FN_RELEASE, 0, 0, KIND_COMMAND, DISP_ACCEPTED, 0, 0, 0, 0, 0));
        push_word(make_word(FN_RELEASE, 0, 0, KIND_COMMAND, DISP_ACCEPTED, 0, 0, 0, 0, 0));
        // release of a lane that does not exist, class out of range too
        push_word(make_word(FN_RELEASE, 15, 15, KIND_RESULT, 3, 0, 0, 0, 0, 0));
        // each way an envelope can be malformed but an oversized payload
        push_word(make_word(FN_ADMIT, 0, 15, KIND_COMMAND, DISP_ACCEPTED, 1, 1, 0, 0, 0));
        push_word(make_word(FN_ADMIT, 9, 0, KIND_COMMAND, DISP_ACCEPTED, 1, 1, 0, 0, 0));
        push_word(make_word(FN_ADMIT, 1, 1, KIND_COMMAND, DISP_ACCEPTED, 0, 1, 0, 0, 0));
        push_word(make_word(FN_ADMIT, 1, 1, KIND_COMMAND, DISP_ACCEPTED, 1, 0, 0, 0, 0));
        push_word(make_word(FN_ADMIT, 1, 1, KIND_COMMAND, 3, 1, 1, 0, 0, 0));
        push_word(make_word(FN_ADMIT, 2, 4, KIND_RESULT, DISP_ACCEPTED, 1, 1, 0, 0, 0));
        // result envelopes always route to the control lane
        push_word(make_word(FN_ADMIT, 2, 4, KIND_RESULT, 2, 1, 1, 0, 0, 0));
        // shared network lane: wrong lane, then a lane with no capacity
        push_word(make_word(FN_ADMIT, 5, 6, KIND_COMMAND, DISP_ACCEPTED, 1, 1, 0, 0, 0));
        push_word(make_word(FN_ADMIT, 6, 7, KIND_COMMAND, DISP_ACCEPTED, 1, 1, 0, 0, 0));
        // floor only rises; zero floor and bad class are rejected
        push_word(make_word(FN_CANCEL, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 100, 0, 0, 0, 0));
        push_word(make_word(FN_CANCEL, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 50, 0, 0, 0, 0));
        push_word(make_word(FN_CANCEL, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 0, 0, 0, 0, 0));
        push_word(make_word(FN_CANCEL, 3, 12, KIND_COMMAND, DISP_ACCEPTED, 5, 0, 0, 0, 0));
        // stale generation, then deadlines: equal, passed across wrap, ahead across
        // wrap, and exactly half the range apart
        push_word(make_word(FN_ADMIT, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 99, 1, 0, 0, 0));
        push_word(make_word(FN_ADMIT, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 100, 1, 0,
                            32'h0000_1234, 32'h0000_1234));
        push_word(make_word(FN_ADMIT, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 100, 1, 0,
                            32'hFFFF_FFF0, 32'h0000_0010));
        push_word(make_word(FN_ADMIT, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 100, 1, 0,
                            32'h0000_0001, 32'hFFFF_FFFF));
        push_word(make_word(FN_ADMIT, 7, 8, KIND_COMMAND, DISP_ACCEPTED, 100, 1, 0,
                            32'h0000_0005, 32'h8000_0005));
        settle();

        // random phases, each under its own register settings
        for (phase = 0; phase < PHASES; phase++) begin
            caps = '0;
            for (k = 0; k < 8; k++) begin
                case (phase)
                    0:       caps[8*k +: 8] = 8'($urandom_range(1, 4));
                    1:       caps[8*k +: 8] = 8'hFF;
                    2:       caps[8*k +: 8] = 8'h00;
                    3:       caps[8*k +: 8] = 8'($urandom);
                    4:       caps[8*k +: 8] = 8'($urandom_range(0, 3));
                    default: caps[8*k +: 8] = 8'($urandom_range(1, 2));
                endcase
            end
            case (phase)
                1:       limit = 32'hFFFF_FFFF;
                2:       limit = 32'd0;
                3:       limit = $urandom;
                4:       limit = $urandom_range(0, 65535);
                default: limit = MAX_PAYLOAD_RESET;
            endcase
            configure(caps, limit);
            // long output hold-off in some phases while words keep coming
            if (phase % 3 == 0) hold_off_req = 1'b1;
            repeat (PHASE_LEN) push_word(next_word());
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outcome_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (sb.outcome_q.size() != 0)
                $display("%0t: %0d result words never arrived", $time, sb.outcome_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
